[design/psf_pkg.sv]
// shared constants and types for the prime sieve filter chain
package psf_pkg;

	localparam int NUM_CELLS_DEF   = 64;
	localparam int VALUE_WIDTH_DEF = 16;
	localparam int CAND_W          = 16;
	localparam int PRIME_W         = 16;
	localparam int MIN_PRIME       = 2;
	localparam int RES_FIFO_DEPTH  = 8;

	// one bit of a candidate moving down the chain, msb first
	typedef struct packed {
		logic valid;
		logic data;
		logic first;
		logic last;
		logic restart;
		logic alive;
		logic stored;
	} flit_t;

	typedef struct packed {
		logic [PRIME_W-1:0] prime_value;
		logic               overflow;
	} res_t;

endpackage

[design/psf_cand_if.sv]
// candidate channel: valid, ready and the candidate payload
interface psf_cand_if import psf_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [CAND_W-1:0] candidate;
	logic              restart;

	modport source (output valid, output candidate, output restart, input ready);
	modport sink (input valid, input candidate, input restart, output ready);
endinterface

[design/psf_prime_if.sv]
// result channel: valid, ready and the prime payload
interface psf_prime_if import psf_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [PRIME_W-1:0] prime_value;
	logic               overflow;

	modport source (output valid, output prime_value, output overflow, input ready);
	modport sink (input valid, input prime_value, input overflow, output ready);
endinterface

[design/prime_sieve_filter_chain.sv]
// top level: serialiser, chain of filter cells, result queue and credit count
//
// Candidates enter on the candidates channel, one beat per item with the
// candidate and its restart flag; results leave on the primes channel with
// the prime and an overflow flag. Values below two, and candidates that a
// stored prime divides, give no result beat.
// Each candidate is sent msb first down the chain, one bit per cycle, and
// every cell that holds a prime reduces it modulo that prime with one
// compare and subtract per bit. The serialiser takes a new candidate only
// while it sends the last bit of the one before, or while idle, and only
// while the credit count allows; several candidates are in the chain at once.
// Restart rides with the first bit and empties each cell just ahead of its
// candidate.
// Reset empties every cell and the result queue. The chain never stops:
// a credit count of items in flight and queued holds ready low while the
// result queue could not take every item already inside, so a stalled
// receiver only stops intake and no result is lost.
module prime_sieve_filter_chain import psf_pkg::*; #(
	parameter int NUM_CELLS   = NUM_CELLS_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	psf_cand_if.sink    candidates,
	psf_prime_if.source primes
);

	localparam int SW = $clog2(VALUE_WIDTH);
	localparam int OW = $clog2(RES_FIFO_DEPTH + 1);

	logic [VALUE_WIDTH-1:0] cand_w;
	logic [VALUE_WIDTH-1:0] shreg_q;
	logic [SW-1:0]          cnt_q;
	logic                   busy_q;
	logic                   restart_q;
	logic                   alive_q;
	logic [OW-1:0]          outstanding_q;
	logic [VALUE_WIDTH-1:0] des_q;
	logic [VALUE_WIDTH-1:0] end_value;

	logic  last_bit;
	logic  accept;
	logic  push;
	logic  drop;
	logic  pop;
	logic  not_empty;
	res_t  push_data;
	res_t  head;
	flit_t chain [NUM_CELLS+1];

	// fit the fixed-width payload to the internal value width
	generate
		if (VALUE_WIDTH > CAND_W) begin : g_wide_in
			assign cand_w = {{(VALUE_WIDTH - CAND_W){1'b0}}, candidates.candidate};
		end else begin : g_narrow_in
			assign cand_w = candidates.candidate[VALUE_WIDTH-1:0];
		end
		if (VALUE_WIDTH >= PRIME_W) begin : g_wide_out
			assign push_data.prime_value = end_value[PRIME_W-1:0];
		end else begin : g_narrow_out
			assign push_data.prime_value = {{(PRIME_W - VALUE_WIDTH){1'b0}}, end_value};
		end
	endgenerate

	assign last_bit = busy_q & (cnt_q == SW'(VALUE_WIDTH - 1));
	assign candidates.ready = (~busy_q | last_bit) & (outstanding_q < OW'(RES_FIFO_DEPTH));
	assign accept = candidates.valid & candidates.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			busy_q <= ~last_bit;
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			shreg_q   <= cand_w;
			restart_q <= candidates.restart;
			alive_q   <= (cand_w >= VALUE_WIDTH'(MIN_PRIME));
		end else if (busy_q) begin
			shreg_q <= {shreg_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	always_comb begin
		chain[0].valid   = busy_q;
		chain[0].data    = shreg_q[VALUE_WIDTH-1];
		chain[0].first   = (cnt_q == '0);
		chain[0].last    = last_bit;
		chain[0].restart = restart_q;
		chain[0].alive   = alive_q;
		chain[0].stored  = 1'b0;
	end

	generate
		for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
			psf_cell #(
				.VALUE_WIDTH(VALUE_WIDTH)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.prev_flit(chain[i]),
				.next_flit(chain[i+1])
			);
		end
	endgenerate

	// gather the bits back at the chain end
	always_ff @(posedge clk) begin
		if (chain[NUM_CELLS].valid) begin
			des_q <= end_value;
		end
	end

	assign end_value = {des_q[VALUE_WIDTH-2:0], chain[NUM_CELLS].data};
	assign push = chain[NUM_CELLS].valid & chain[NUM_CELLS].last & chain[NUM_CELLS].alive;
	assign drop = chain[NUM_CELLS].valid & chain[NUM_CELLS].last & ~chain[NUM_CELLS].alive;
	assign push_data.overflow = ~chain[NUM_CELLS].stored;

	psf_res_fifo #(
		.DEPTH(RES_FIFO_DEPTH)
	) u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.not_empty(not_empty),
		.head     (head)
	);

	assign primes.valid       = not_empty;
	assign primes.prime_value = head.prime_value;
	assign primes.overflow    = head.overflow;
	assign pop                = not_empty & primes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + OW'(accept) - OW'(pop) - OW'(drop);
		end
	end

`ifndef SYNTHESIS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= OW'(RES_FIFO_DEPTH))
		else $error("more items inside than the result queue can hold");
	a_end_needs_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(push || drop || pop) |-> (outstanding_q != '0))
		else $error("item left the block without a credit");
	a_accept_between_items: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!busy_q || last_bit))
		else $error("candidate accepted while the serialiser was mid-item");
`endif

endmodule

[design/psf_cell.sv]
// one filter cell: holds a prime and reduces the passing candidate modulo it, bit by bit
module psf_cell import psf_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  flit_t prev_flit,
	output flit_t next_flit
);

	logic                   used_q;
	logic [VALUE_WIDTH-1:0] prime_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	flit_t                  flit_q;

	logic                   used_eff;
	logic [VALUE_WIDTH-1:0] rem_base;
	logic [VALUE_WIDTH:0]   rem_sh;
	logic [VALUE_WIDTH:0]   rem_sub;
	logic [VALUE_WIDTH-1:0] rem_nx;
	logic                   decide;
	logic                   store;
	logic                   kill;
	flit_t                  flit_nx;

	always_comb begin
		// restart travels with the first bit and empties the cell ahead of it
		used_eff = used_q & ~(prev_flit.valid & prev_flit.first & prev_flit.restart);
		rem_base = prev_flit.first ? '0 : rem_q;
		rem_sh   = {rem_base, prev_flit.data};
		rem_sub  = rem_sh - {1'b0, prime_q};
		rem_nx   = (rem_sh >= {1'b0, prime_q}) ? rem_sub[VALUE_WIDTH-1:0]
			: rem_sh[VALUE_WIDTH-1:0];
		decide   = prev_flit.valid & prev_flit.last & prev_flit.alive & ~prev_flit.stored;
		kill     = decide & used_eff & (rem_nx == '0);
		store    = decide & ~used_eff;
		flit_nx        = prev_flit;
		flit_nx.alive  = prev_flit.alive & ~kill;
		flit_nx.stored = prev_flit.stored | store;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			flit_q <= '0;
		end else begin
			flit_q <= flit_nx;
			if (prev_flit.valid) begin
				used_q <= used_eff | store;
			end
		end
	end

	// an empty cell shifts the candidate in so it holds it once stored
	always_ff @(posedge clk) begin
		if (prev_flit.valid) begin
			rem_q <= rem_nx;
			if (!used_eff) begin
				prime_q <= {prime_q[VALUE_WIDTH-2:0], prev_flit.data};
			end
		end
	end

	assign next_flit = flit_q;

endmodule

[design/psf_res_fifo.sv]
// small result queue between the chain end and the output channel
module psf_res_fifo import psf_pkg::*; #(
	parameter int DEPTH = RES_FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	input  logic pop,
	output logic not_empty,
	output res_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	res_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CW'(DEPTH)))
		else $error("result queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("result queue read while empty");
`endif

endmodule

[test/prime_sieve_filter_chain_tb.sv]
// testbench for the prime sieve filter chain: queued stimulus, sieve predictor and result checks
module prime_sieve_filter_chain_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import psf_pkg::*;

	localparam int CHAIN_LEN    = NUM_CELLS_DEF;
	localparam int LATENCY      = NUM_CELLS_DEF + VALUE_WIDTH_DEF;
	localparam int ITEM_TARGET  = 550;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AT      = 120;
	localparam int CALM_FROM    = 260;
	localparam int CALM_TO      = 340;
	localparam int IDLE_PERCENT = 35;

	typedef struct packed {
		logic [CAND_W-1:0] value;
		logic              clear;
	} cand_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	psf_cand_if  cand_ch ();
	psf_prime_if prime_ch ();

	prime_sieve_filter_chain i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.candidates (cand_ch),
		.primes     (prime_ch)
	);

	cand_item_t         cands_to_send[$];
	res_t               primes_due[$];
	logic [PRIME_W-1:0] sieve_primes[CHAIN_LEN];
	int unsigned        sieve_fill;
	int unsigned        cands_taken;
	int unsigned        faults;
	int unsigned        hold_left;
	logic               hold_started;
	cand_item_t         next_cand;
	res_t               due;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mirror of the chain: stored primes form a prefix, filled in order
	function automatic void sieve_step(logic [CAND_W-1:0] value, logic clear);
		if (clear)
			sieve_fill = 0;
		if (value < MIN_PRIME)
			return;
		for (int k = 0; k < sieve_fill; k++)
			if (value % sieve_primes[k] == 0)
				return;
		if (sieve_fill < CHAIN_LEN) begin
			sieve_primes[sieve_fill] = value;
			sieve_fill++;
			primes_due.push_back('{prime_value: value, overflow: 1'b0});
		end else begin
			primes_due.push_back('{prime_value: value, overflow: 1'b1});
		end
	endfunction

	// no idling at all while the calm window is open
	function automatic logic side_rests();
		if (cands_taken >= CALM_FROM && cands_taken < CALM_TO)
			return 1'b0;
		return $urandom_range(0, 99) < IDLE_PERCENT;
	endfunction

	function automatic void queue_cand(int unsigned value, logic clear);
		cands_to_send.push_back('{value: value[CAND_W-1:0], clear: clear});
	endfunction

	// candidate driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_ch.valid     <= 1'b0;
			cand_ch.candidate <= '0;
			cand_ch.restart   <= 1'b0;
		end else begin
			if (cand_ch.valid && cand_ch.ready) begin
				sieve_step(cand_ch.candidate, cand_ch.restart);
				cands_taken++;
			end
			if (!cand_ch.valid || cand_ch.ready) begin
				// keep offering while the receiver is held off so intake backs up
				if (cands_to_send.size() > 0 && (hold_left > 0 || !side_rests())) begin
					next_cand = cands_to_send.pop_front();
					cand_ch.valid     <= 1'b1;
					cand_ch.candidate <= next_cand.value;
					cand_ch.restart   <= next_cand.clear;
				end else begin
					cand_ch.valid <= 1'b0;
				end
			end
		end
	end

	// prime monitor and receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_ch.ready <= 1'b0;
		end else begin
			if (prime_ch.valid && prime_ch.ready) begin
				if (primes_due.size() == 0) begin
					$error("unexpected beat: prime_value %0d overflow %0b",
						prime_ch.prime_value, prime_ch.overflow);
					faults++;
				end else begin
					due = primes_due.pop_front();
					if (prime_ch.prime_value !== due.prime_value) begin
						$error("prime_value: expected %0d, actual %0d",
							due.prime_value, prime_ch.prime_value);
						faults++;
					end
					if (prime_ch.overflow !== due.overflow) begin
						$error("overflow: expected %0b, actual %0b",
							due.overflow, prime_ch.overflow);
						faults++;
					end
				end
			end
			if (!hold_started && cands_taken >= HOLD_AT) begin
				hold_started = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				prime_ch.ready <= 1'b0;
			end else begin
				prime_ch.ready <= !side_rests();
			end
		end
	end

	initial begin
		int kind;
		int len;
		int unsigned base;
		int unsigned run_next;
		logic first_run;

		cand_ch.valid     = 1'b0;
		cand_ch.candidate = '0;
		cand_ch.restart   = 1'b0;
		prime_ch.ready    = 1'b0;
		sieve_fill   = 0;
		cands_taken  = 0;
		faults       = 0;
		hold_left    = 0;
		hold_started = 1'b0;

		// directed: small values, repeats, out of order composites, extremes
		queue_cand(0, 1'b1);
		queue_cand(1, 1'b0);
		queue_cand(2, 1'b0);
		queue_cand(2, 1'b0);
		queue_cand(3, 1'b0);
		queue_cand(4, 1'b0);
		queue_cand(9, 1'b0);
		queue_cand(25, 1'b0);
		queue_cand(5, 1'b0);
		queue_cand(125, 1'b0);
		queue_cand(65535, 1'b0);
		queue_cand(65521, 1'b0);
		queue_cand(32768, 1'b0);
		queue_cand(1, 1'b1);
		queue_cand(65535, 1'b1);
		queue_cand(0, 1'b0);
		queue_cand(32768, 1'b0);
		queue_cand(16'hAAAA, 1'b0);
		queue_cand(16'h5555, 1'b0);
		queue_cand(2, 1'b1);
		queue_cand(3, 1'b0);

		// random runs; the first one always fills the chain to overflow
		run_next = 4;
		first_run = 1'b1;
		while (cands_to_send.size() < ITEM_TARGET) begin
			kind = first_run ? 5 : $urandom_range(0, 9);
			first_run = 1'b0;
			case (kind)
				0, 1, 2, 3, 4: begin
					// ordinary sieve from two upwards
					len = $urandom_range(15, 90);
					for (int k = 0; k < len; k++)
						queue_cand(2 + k, k == 0);
					run_next = 2 + len;
				end
				5, 6: begin
					// values above half range never divide one another
					base = $urandom_range(32768, 65535 - 80);
					len = $urandom_range(66, 72);
					for (int k = 0; k < len; k++)
						queue_cand(base + k, k == 0);
					run_next = base + len;
				end
				7: begin
					len = $urandom_range(1, 8);
					for (int k = 0; k < len; k++)
						queue_cand(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1)
							: $urandom_range(0, 65535), $urandom_range(0, 15) == 0);
				end
				default: begin
					// carry on where the last run stopped, now and then a step back
					len = $urandom_range(5, 30);
					for (int k = 0; k < len; k++) begin
						queue_cand(run_next, 1'b0);
						run_next = (run_next + 1) & 16'hFFFF;
					end
					if ($urandom_range(0, 1))
						queue_cand($urandom_range(2, 400), 1'b0);
				end
			endcase
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (cands_to_send.size() > 0 || cand_ch.valid)
			@(posedge clk);
		while (primes_due.size() > 0)
			@(posedge clk);
		// catch any stray beat after the last expected one
		repeat (2 * LATENCY) @(posedge clk);

		if (faults == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
